### hdl/dq_pkg.sv
// shared types and constants for the double-ended queue
package dq_pkg;

  localparam int unsigned DepthDefault = 128;
  localparam int unsigned DataW        = 32;
  localparam int unsigned CapW         = 8;
  localparam int unsigned FuncW        = 2;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned OutTdataW    = 40;

  localparam logic [CapW-1:0] CapReset = 8'd128;

  typedef enum logic [FuncW-1:0] {
    FUNC_PUSH   = 2'd0,
    FUNC_POP    = 2'd1,
    FUNC_INJECT = 2'd2,
    FUNC_EJECT  = 2'd3
  } func_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic load_out;
  } dq_cmd_t;

  typedef struct packed {
    logic out_free;
  } dq_sts_t;

endpackage

### hdl/dq_ctrl.sv
// sequencer: accept, execute against the store, hand result to output register
module dq_ctrl
  import dq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dq_sts_t sts_i,
  output dq_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_e;

  state_e state_q, state_d;
  logic   ready_q, ready_d;

  always_comb begin
    state_d          = state_q;
    ready_d          = ready_q;
    cmd_o.load_in    = 1'b0;
    cmd_o.exec       = 1'b0;
    cmd_o.load_out   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && ready_q) begin
          cmd_o.load_in = 1'b1;
          ready_d       = 1'b0;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_RESP;
      end
      ST_RESP: begin
        // wait here while the previous result still sits unclaimed
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          ready_d        = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        ready_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b1;
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
    end
  end

  assign in_ready_o = ready_q;

`ifndef SYNTHESIS
  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |-> (state_q == ST_IDLE))
    else $error("input ready outside idle");
`endif

endmodule

### hdl/dq_datapath.sv
// ring store with head and count, operation decode, result and output registers
module dq_datapath
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dq_cmd_t            cmd_i,
  output dq_sts_t            sts_o,
  input  logic [FuncW-1:0]   func_i,
  input  logic [DataW-1:0]   item_value_i,
  input  logic               cap_we_i,
  input  logic [CapW-1:0]    cap_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [StatusW-1:0] out_status_o,
  output logic [DataW-1:0]   out_removed_value_o,
  output logic               out_removed_valid_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned SW   = CW + 1;
  localparam int unsigned CMPW = (CW > CapW) ? CW : CapW;

  logic [DataW-1:0] mem_q [DEPTH];
  logic [DataW-1:0] rd_data_q;

  func_e            func_q;
  logic [DataW-1:0] value_q;
  logic [AW-1:0]    head_q, head_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CapW-1:0]  capacity_q;
  status_e          status_q, status_d;
  logic             got_q;

  logic               out_valid_q;
  status_e            out_status_q;
  logic [DataW-1:0]   out_removed_q;
  logic               out_rvalid_q;

  logic          is_ins, is_empty, is_full;
  logic [AW-1:0] head_dec, head_inc, tail_pos, addr;
  logic [CW-1:0] offset;
  logic [SW-1:0] tail_sum;
  logic          wr_en, rd_en;

  assign is_ins   = (func_q == FUNC_PUSH) || (func_q == FUNC_INJECT);
  assign is_empty = (count_q == '0);
  assign is_full  = (CMPW'(count_q) >= CMPW'(capacity_q)) || (count_q >= CW'(DEPTH));

  assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;
  assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;

  // rear slot: head + count for inject, head + count - 1 for eject
  assign offset   = (func_q == FUNC_EJECT) ? count_q - 1'b1 : count_q;
  assign tail_sum = SW'(head_q) + SW'(offset);
  assign tail_pos = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);

  always_comb begin
    case (func_q)
      FUNC_PUSH: addr = head_dec;
      FUNC_POP:  addr = head_q;
      default:   addr = tail_pos;
    endcase
  end

  assign wr_en = cmd_i.exec && is_ins && !is_full;
  assign rd_en = cmd_i.exec && !is_ins && !is_empty;

  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    status_d = status_q;
    if (cmd_i.exec) begin
      status_d = STATUS_OK;
      if (is_ins && is_full) begin
        status_d = STATUS_FULL;
      end else if (!is_ins && is_empty) begin
        status_d = STATUS_EMPTY;
      end
    end
    if (wr_en) begin
      count_d = count_q + 1'b1;
      if (func_q == FUNC_PUSH) begin
        head_d = head_dec;
      end
    end
    if (rd_en) begin
      count_d = count_q - 1'b1;
      if (func_q == FUNC_POP) begin
        head_d = head_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[addr] <= value_q;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      func_q  <= func_e'(func_i);
      value_q <= item_value_i;
    end
    status_q <= status_d;
    if (cmd_i.exec) begin
      got_q <= rd_en;
    end
    if (cmd_i.load_out) begin
      out_status_q  <= status_q;
      out_removed_q <= got_q ? rd_data_q : '0;
      out_rvalid_q  <= got_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      capacity_q  <= CapReset;
      out_valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      if (cap_we_i) begin
        capacity_q <= cap_data_i;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_free      = !out_valid_q || out_ready_i;
  assign out_valid_o         = out_valid_q;
  assign out_status_o        = out_status_q;
  assign out_removed_value_o = out_removed_q;
  assign out_removed_valid_o = out_rvalid_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= AW'(DEPTH - 1))
    else $error("head index outside ring");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.exec |=> $stable(count_q) && $stable(head_q))
    else $error("ring pointers moved without an operation");

  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && is_ins && is_full |=> $stable(count_q) && (status_q == STATUS_FULL))
    else $error("insert into full queue changed state");
`endif

endmodule

### hdl/double_ended_queue.sv
// bounded double-ended queue: push/pop at front, inject/eject at rear
// steps per item: accept, execute on the single-port store, respond
// the input is not ready again until the result is handed to the output register
// a new item is accepted while the previous result beat still waits on m_axis_tready_i
// reset (async, active low) clears head, count and output valid; capacity returns to 128
// the entry store is not cleared: only entries written by a push or inject are read
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [DataW-1:0]     s_axis_tdata_i,   // [31:0] item_value
  input  logic [FuncW-1:0]     s_axis_tuser_i,   // [1:0] func
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [OutTdataW-1:0] m_axis_tdata_o,   // [1:0] status, [33:2] removed_value
  output logic                 m_axis_tuser_o,   // [0] removed_valid
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CapW-1:0]      cfg_data_i        // capacity
);

  dq_cmd_t            cmd;
  dq_sts_t            sts;
  logic [StatusW-1:0] out_status;
  logic [DataW-1:0]   out_removed;

  assign cfg_ready_o = 1'b1;

  dq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .func_i              (s_axis_tuser_i),
    .item_value_i        (s_axis_tdata_i),
    .cap_we_i            (cfg_valid_i),
    .cap_data_i          (cfg_data_i),
    .out_valid_o         (m_axis_tvalid_o),
    .out_ready_i         (m_axis_tready_i),
    .out_status_o        (out_status),
    .out_removed_value_o (out_removed),
    .out_removed_valid_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {6'd0, out_removed, out_status};

endmodule

### test/tb_double_ended_queue.sv
// self-checking testbench for the bounded double-ended queue
module tb_double_ended_queue;
  import dq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdxW          = $clog2(DepthDefault);
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned EndCycles     = 10;

  typedef struct {
    func_e       func;
    logic [31:0] value;
  } deque_op_t;

  typedef struct {
    status_e     status;
    logic [31:0] removed_value;
    logic        removed_valid;
  } deque_result_t;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [DataW-1:0]     s_axis_tdata_i  = '0;  // [31:0] item_value
  logic [FuncW-1:0]     s_axis_tuser_i  = '0;  // [1:0] func
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata_o;        // [1:0] status, [33:2] removed_value
  logic                 m_axis_tuser_o;        // [0] removed_valid
  logic                 cfg_valid_i     = 1'b0;
  logic                 cfg_ready_o;
  logic [CapW-1:0]      cfg_data_i      = '0;  // capacity

  double_ended_queue uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // predicted deque contents
  logic [31:0]     model_store [DepthDefault];
  logic [IdxW-1:0] model_head     = '0;
  logic [CapW-1:0] model_count    = '0;
  logic [CapW-1:0] model_capacity = CapReset;

  deque_op_t     pending_ops[$];
  deque_result_t expected_results[$];
  deque_op_t     offered_op;

  int unsigned items_queued  = 0;
  int unsigned results_seen  = 0;
  int unsigned mismatches    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_off      = 1'b0;
  event        start_hold_off;

  function automatic deque_result_t apply_op(input deque_op_t op);
    deque_result_t   res;
    logic [IdxW-1:0] pos;
    int unsigned     limit;
    res.status        = STATUS_OK;
    res.removed_value = '0;
    res.removed_valid = 1'b0;
    limit = (model_capacity > DepthDefault) ? DepthDefault : model_capacity;
    if (op.func == FUNC_PUSH || op.func == FUNC_INJECT) begin
      if (model_count >= limit) begin
        res.status = STATUS_FULL;
      end else begin
        if (op.func == FUNC_PUSH) begin
          model_head = model_head - 1'b1;
          pos = model_head;
        end else begin
          pos = model_head + model_count[IdxW-1:0];
        end
        model_store[pos] = op.value;
        model_count = model_count + 1'b1;
      end
    end else begin
      if (model_count == 0) begin
        res.status = STATUS_EMPTY;
      end else begin
        if (op.func == FUNC_POP) begin
          pos = model_head;
          model_head = model_head + 1'b1;
        end else begin
          pos = model_head + model_count[IdxW-1:0] - 1'b1;
        end
        res.removed_value = model_store[pos];
        res.removed_valid = 1'b1;
        model_count = model_count - 1'b1;
      end
    end
    return res;
  endfunction

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // sender: predicts each accepted beat, then offers the next pending op
  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      expected_results.push_back(apply_op(offered_op));
    end
    if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        offered_op = pending_ops.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= offered_op.value;
        s_axis_tuser_i  <= offered_op.func;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // receiver: checks result beats against the oldest prediction
  always @(posedge clk_i) begin
    deque_result_t want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        note_failure($sformatf("result beat with nothing expected, tdata=%h tuser=%b",
                               m_axis_tdata_o, m_axis_tuser_o));
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata_o[1:0] !== want.status) begin
          note_failure($sformatf("status: expected %s got %0d",
                                 want.status.name(), m_axis_tdata_o[1:0]));
        end
        if (m_axis_tdata_o[33:2] !== want.removed_value) begin
          note_failure($sformatf("removed_value: expected %0d got %0d",
                                 $signed(want.removed_value), $signed(m_axis_tdata_o[33:2])));
        end
        if (m_axis_tuser_o !== want.removed_valid) begin
          note_failure($sformatf("removed_valid: expected %b got %b",
                                 want.removed_valid, m_axis_tuser_o));
        end
      end
    end
    m_axis_tready_i <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // long output hold-off so the block backs up and stalls its input
  initial begin
    forever begin
      @(start_hold_off);
      hold_off <= 1'b1;
      repeat (HoldOffCycles) @(posedge clk_i);
      hold_off <= 1'b0;
    end
  end

  task automatic enqueue_op(input func_e func, input logic [31:0] value);
    deque_op_t op;
    op.func  = func;
    op.value = value;
    pending_ops.push_back(op);
    items_queued++;
  endtask

  function automatic logic [31:0] random_value();
    case ($urandom_range(7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // alternating fill and drain runs, so full and empty are both reached
  task automatic queue_random(input int unsigned count, input int unsigned fill_pct,
                              input int unsigned first_run);
    int unsigned run_left;
    int unsigned insert_pct;
    func_e       func;
    run_left   = first_run;
    insert_pct = fill_pct;
    repeat (count) begin
      if (run_left == 0) begin
        run_left   = $urandom_range(48, 1);
        insert_pct = (insert_pct == fill_pct) ? 100 - fill_pct : fill_pct;
      end
      run_left--;
      if ($urandom_range(99) < insert_pct) begin
        func = $urandom_range(1) ? FUNC_PUSH : FUNC_INJECT;
      end else begin
        func = $urandom_range(1) ? FUNC_POP : FUNC_EJECT;
      end
      enqueue_op(func, random_value());
    end
  endtask

  task automatic wait_idle();
    while (results_seen != items_queued) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CapW-1:0] cap);
    wait_idle();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    model_capacity = cap;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(input logic [CapW-1:0] cap, input int unsigned send_idle,
                              input int unsigned recv_stall, input int unsigned count,
                              input int unsigned fill_pct, input int unsigned first_run);
    write_capacity(cap);
    send_idle_pct  = send_idle;
    recv_stall_pct = recv_stall;
    queue_random(count, fill_pct, first_run);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty deque, value extremes at both ends, removal order
    enqueue_op(FUNC_POP,    32'h1234_5678);
    enqueue_op(FUNC_EJECT,  32'h0);
    enqueue_op(FUNC_PUSH,   32'h7fff_ffff);
    enqueue_op(FUNC_PUSH,   32'h8000_0000);
    enqueue_op(FUNC_INJECT, 32'hffff_ffff);
    enqueue_op(FUNC_INJECT, 32'h0);
    enqueue_op(FUNC_POP,    32'h0);
    enqueue_op(FUNC_EJECT,  32'h0);
    enqueue_op(FUNC_POP,    32'h0);
    enqueue_op(FUNC_EJECT,  32'h0);

    // full at a small capacity
    write_capacity(8'd2);
    enqueue_op(FUNC_INJECT, 32'h5555_5555);
    enqueue_op(FUNC_PUSH,   32'haaaa_aaaa);
    enqueue_op(FUNC_INJECT, 32'h1);
    enqueue_op(FUNC_PUSH,   32'h2);
    enqueue_op(FUNC_EJECT,  32'h0);
    enqueue_op(FUNC_POP,    32'h0);

    // zero capacity never takes an entry
    write_capacity(8'd0);
    enqueue_op(FUNC_PUSH,   32'h3);
    enqueue_op(FUNC_INJECT, 32'h4);
    enqueue_op(FUNC_POP,    32'h0);

    // capacity lowered below the current count keeps the held entries
    write_capacity(8'd3);
    enqueue_op(FUNC_INJECT, 32'h11);
    enqueue_op(FUNC_INJECT, 32'h22);
    enqueue_op(FUNC_INJECT, 32'h33);
    write_capacity(8'd1);
    enqueue_op(FUNC_PUSH,   32'h44);
    enqueue_op(FUNC_POP,    32'h0);
    enqueue_op(FUNC_INJECT, 32'h55);
    enqueue_op(FUNC_EJECT,  32'h0);
    enqueue_op(FUNC_POP,    32'h0);
    enqueue_op(FUNC_INJECT, 32'h66);
    enqueue_op(FUNC_PUSH,   32'h77);

    random_phase(8'd128, 0,  0,  150, 70, 60);
    // capacity above the store depth, filled past 128 requests
    random_phase(8'd255, 75, 0,  200, 95, 150);
    random_phase(8'd1,   0,  75, 80,  60, 10);
    random_phase(8'd7,   24, 24, 120, 75, 20);
    random_phase(8'd64,  75, 0,  120, 80, 70);
    random_phase(8'd0,   0,  0,  30,  60, 10);
    random_phase(8'd128, 0,  75, 120, 70, 40);
    random_phase(8'd200, 24, 24, 100, 65, 30);

    // back-pressure: receiver holds off while the sender keeps offering
    wait_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    -> start_hold_off;
    queue_random(80, 70, 40);

    wait_idle();
    repeat (EndCycles) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", expected_results.size()));
    end
    if (mismatches == 0) begin
      $display("tb_double_ended_queue passed");
    end else begin
      $display("tb_double_ended_queue failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_double_ended_queue failed");
    $finish;
  end

endmodule
